// ===== design/udlf_pkg.sv =====
// ----------------------------------------------------------------------------
// udlf_pkg
// Shared types, constants and fold function for the decorated-letter folder.
// ----------------------------------------------------------------------------
package udlf_pkg;

	localparam int unsigned CpW = 21;
	localparam int unsigned QueueDepth = 2;

	// Folded code point handed from the front part to the back part
	typedef struct packed {
		logic [CpW-1:0] cp;
	} cp_word_t;

	// Fold a complete code point to plain ASCII where it is decorated
	function automatic logic [CpW-1:0] fold_code(input logic [CpW-1:0] c);
		logic [CpW-1:0] d;
		logic [CpW-1:0] r;
		logic [CpW-1:0] res;
		d = '0;
		r = '0;
		res = c;
		if (c >= 21'd119808 && c <= 21'd120483) begin
			d = c - 21'd119808;
			// index below 676: remainder by 52 through reciprocal 1261/65536
			r = d - CpW'(((d * 21'd1261) >> 16) * 21'd52);
			if (r >= 21'd52) r = r - 21'd52;
			res = (r >= 21'd26) ? r + 21'd71 : r + 21'd65;
		end else if (c >= 21'd120782 && c <= 21'd120831) begin
			d = c - 21'd120782;
			r = d - CpW'(((d * 21'd205) >> 11) * 21'd10);
			if (r >= 21'd10) r = r - 21'd10;
			res = r + 21'd48;
		end
		else if (c >= 21'd65296 && c <= 21'd65305) res = c - 21'd65248;
		else if (c >= 21'd65313 && c <= 21'd65338) res = c - 21'd65248;
		else if (c >= 21'd65345 && c <= 21'd65370) res = c - 21'd65248;
		else if (c >= 21'd9398 && c <= 21'd9423) res = c - 21'd9333;
		else if (c >= 21'd9424 && c <= 21'd9449) res = c - 21'd9327;
		else if (c >= 21'd9312 && c <= 21'd9320) res = c - 21'd9263;
		else if (c >= 21'd9372 && c <= 21'd9397) res = c - 21'd9275;
		else if (c >= 21'd127312 && c <= 21'd127337) res = c - 21'd127247;
		else if (c >= 21'd127344 && c <= 21'd127369) res = c - 21'd127279;
		else if (c >= 21'd127280 && c <= 21'd127305) res = c - 21'd127215;
		else if (c >= 21'd8308 && c <= 21'd8313) res = c - 21'd8256;
		else if (c >= 21'd8320 && c <= 21'd8329) res = c - 21'd8272;
		else begin
			case (c)
				21'd120484: res = 21'd105;
				21'd120485: res = 21'd106;
				21'd8450, 21'd8493, 21'd7428: res = 21'd67;
				21'd8469, 21'd628: res = 21'd78;
				21'd8484, 21'd8488, 21'd7458: res = 21'd90;
				21'd8492, 21'd665: res = 21'd66;
				21'd8499, 21'd7437: res = 21'd77;
				21'd8500, 21'd7506, 21'd8338: res = 21'd111;
				21'd8458, 21'd7501: res = 21'd103;
				21'd8459, 21'd8460, 21'd8461, 21'd668: res = 21'd72;
				21'd8462, 21'd688, 21'd8341: res = 21'd104;
				21'd8464, 21'd8465, 21'd618: res = 21'd73;
				21'd8466, 21'd671: res = 21'd76;
				21'd8467, 21'd737, 21'd8343: res = 21'd108;
				21'd8473, 21'd7448: res = 21'd80;
				21'd8474: res = 21'd81;
				21'd8475, 21'd8476, 21'd8477, 21'd640: res = 21'd82;
				21'd8495, 21'd7497, 21'd8337: res = 21'd101;
				21'd8496, 21'd7431: res = 21'd69;
				21'd8497, 21'd42800: res = 21'd70;
				21'd9450, 21'd8304: res = 21'd48;
				21'd42801: res = 21'd83;
				21'd7457: res = 21'd87;
				21'd7456: res = 21'd86;
				21'd7452: res = 21'd85;
				21'd7451: res = 21'd84;
				21'd7439: res = 21'd79;
				21'd7435: res = 21'd75;
				21'd7434: res = 21'd74;
				21'd7429: res = 21'd68;
				21'd7424: res = 21'd65;
				21'd655: res = 21'd89;
				21'd610: res = 21'd71;
				21'd7491, 21'd8336: res = 21'd97;
				21'd7515: res = 21'd118;
				21'd7580: res = 21'd99;
				21'd7584: res = 21'd102;
				21'd7611: res = 21'd122;
				21'd8305: res = 21'd105;
				21'd8319, 21'd8345: res = 21'd110;
				21'd690: res = 21'd106;
				21'd691: res = 21'd114;
				21'd695: res = 21'd119;
				21'd696: res = 21'd121;
				21'd7503, 21'd8342: res = 21'd107;
				21'd7504, 21'd8344: res = 21'd109;
				21'd739, 21'd8339: res = 21'd120;
				21'd738, 21'd8347: res = 21'd115;
				21'd7495: res = 21'd98;
				21'd7496: res = 21'd100;
				21'd7512: res = 21'd117;
				21'd7511, 21'd8348: res = 21'd116;
				21'd7510, 21'd8346: res = 21'd112;
				21'd185: res = 21'd49;
				21'd178: res = 21'd50;
				21'd179: res = 21'd51;
				default: res = c;
			endcase
		end
		return res;
	endfunction

endpackage

// ===== design/udlf_front.sv =====
// ----------------------------------------------------------------------------
// udlf_front
// Assembles code points from bytes, folds them and pushes them to the queue.
// ----------------------------------------------------------------------------
module udlf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	output logic                push,
	output udlf_pkg::cp_word_t  push_word,
	input  logic                full
);
	import udlf_pkg::*;

	logic [CpW-1:0] code_accum_q;
	logic [1:0]     bytes_left_q;
	logic [CpW-1:0] next_accum;
	logic [CpW-1:0] done_cp;
	logic           done;
	logic           fire;

	assign in_ready = !full;
	assign fire     = in_valid && in_ready;

	// Classify the byte and form the next accumulator
	always_comb begin
		next_accum = code_accum_q;
		done_cp    = {{(CpW-8){1'b0}}, in_byte};
		done       = 1'b0;
		if (bytes_left_q != 2'd0) begin
			next_accum = {code_accum_q[CpW-7:0], in_byte[5:0]};
			done_cp    = next_accum;
			done       = (bytes_left_q == 2'd1);
		end else if (in_byte[7:5] == 3'b110) begin
			next_accum = {{(CpW-5){1'b0}}, in_byte[4:0]};
		end else if (in_byte[7:4] == 4'b1110) begin
			next_accum = {{(CpW-4){1'b0}}, in_byte[3:0]};
		end else if (in_byte[7:3] == 5'b11110) begin
			next_accum = {{(CpW-3){1'b0}}, in_byte[2:0]};
		end else begin
			done = 1'b1;
		end
	end

	// Advance decode state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_accum_q <= '0;
			bytes_left_q <= 2'd0;
		end else if (fire) begin
			code_accum_q <= next_accum;
			if (bytes_left_q != 2'd0) bytes_left_q <= bytes_left_q - 2'd1;
			else if (in_byte[7:5] == 3'b110) bytes_left_q <= 2'd1;
			else if (in_byte[7:4] == 4'b1110) bytes_left_q <= 2'd2;
			else if (in_byte[7:3] == 5'b11110) bytes_left_q <= 2'd3;
		end
	end

	assign push         = fire && done;
	assign push_word.cp = fold_code(done_cp);

endmodule

// ===== design/udlf_queue.sv =====
// ----------------------------------------------------------------------------
// udlf_queue
// Short FIFO of folded code points between front and back parts.
// ----------------------------------------------------------------------------
module udlf_queue #(
	parameter int unsigned DEPTH = udlf_pkg::QueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  udlf_pkg::cp_word_t push_word,
	output logic               full,
	output logic               not_empty,
	output udlf_pkg::cp_word_t head,
	input  logic               pop
);
	import udlf_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cp_word_t         mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [AW:0]      cnt_q;

	assign full      = (cnt_q == (AW+1)'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_word;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

// ===== design/udlf_back.sv =====
// ----------------------------------------------------------------------------
// udlf_back
// Re-encodes queued code points as UTF-8 bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module udlf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               not_empty,
	input  udlf_pkg::cp_word_t head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               run_last
);
	import udlf_pkg::*;

	logic [1:0]     idx_q;
	logic [1:0]     nbytes;
	logic [CpW-1:0] c;
	logic [7:0]     b0, b1, b2, b3, sel;
	logic           last;
	logic           load;

	assign c = head.cp;

	// Build the encoding of the head code point
	always_comb begin
		b1 = 8'h80 | {2'b0, c[17:12]};
		b2 = 8'h80 | {2'b0, c[11:6]};
		b3 = 8'h80 | {2'b0, c[5:0]};
		if (c < 21'h80) begin
			nbytes = 2'd0; b0 = c[7:0];
		end else if (c < 21'h800) begin
			nbytes = 2'd1; b0 = 8'hC0 | {3'b0, c[10:6]};
			b1 = 8'h80 | {2'b0, c[5:0]};
		end else if (c < 21'h10000) begin
			nbytes = 2'd2; b0 = 8'hE0 | {4'b0, c[15:12]};
			b1 = 8'h80 | {2'b0, c[11:6]};
			b2 = 8'h80 | {2'b0, c[5:0]};
		end else begin
			nbytes = 2'd3; b0 = 8'hF0 | {3'b0, c[20:18]};
		end
		unique case (idx_q)
			2'd0: sel = b0;
			2'd1: sel = b1;
			2'd2: sel = b2;
			default: sel = b3;
		endcase
		last = (idx_q == nbytes);
	end

	// Output register: load when empty or being taken
	assign load = !out_valid || out_ready;
	assign pop  = load && not_empty && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			idx_q     <= 2'd0;
		end else if (load) begin
			out_valid <= not_empty;
			if (not_empty) idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && not_empty) begin
			out_byte <= sel;
			run_last <= last;
		end
	end

endmodule

// ===== design/utf8_decorated_letter_folder.sv =====
// ----------------------------------------------------------------------------
// utf8_decorated_letter_folder
// UTF-8 transcoder that folds decorated letters and digits to plain ASCII.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_byte takes one UTF-8 byte per word.
//   Output channel out_valid/out_ready/out_byte/run_last gives the bytes of
//   each re-encoded code point; run_last marks the final byte of a run.
//   A completed code point is folded in the front part and queued; the back
//   part emits its 1 to 4 bytes, one per cycle while out_ready is high,
//   through an output register. A code point whose last byte is accepted
//   is written to the queue, and its first output byte is then loaded into
//   the output register. Throughput: one input byte per cycle while the
//   queue has room; output is one byte per cycle, so code points whose
//   encoding is longer than their input fill the queue and hold in_ready low.
//   When the receiver stalls, the output register holds and the queue fills,
//   then in_ready drops. Reset clears the queue, the output register and any
//   partially assembled code point.
// ----------------------------------------------------------------------------
module utf8_decorated_letter_folder #(
	parameter int unsigned QUEUE_DEPTH = udlf_pkg::QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last
);
	import udlf_pkg::*;

	logic     push, full, not_empty, pop;
	cp_word_t push_word, head;

	udlf_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_byte,
		.push, .push_word, .full
	);

	udlf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n, .push, .push_word, .full, .not_empty, .head, .pop
	);

	udlf_back u_back (
		.clk, .arst_n, .not_empty, .head, .pop,
		.out_valid, .out_ready, .out_byte, .run_last
	);

endmodule

// ===== design/udlf_checker.sv =====
// ----------------------------------------------------------------------------
// udlf_checker
// Port-level checks for the decorated-letter folder.
// ----------------------------------------------------------------------------
module udlf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] in_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_last
);
	// Hold a stalled input word
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_byte))
		else $error("input word changed under stall");

	// Hold a stalled output word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
		else $error("output word changed under stall");

	// A plain ASCII result byte always ends its run
	a_ascii_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_byte[7] |-> run_last)
		else $error("ASCII byte not marked last");

	// A lead byte of a multi-byte run is never last
	a_lead_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_byte[7] && out_byte[6] |-> !run_last)
		else $error("lead byte marked last");

	// Nothing shows on the output right after reset
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid after reset");
endmodule

bind utf8_decorated_letter_folder udlf_checker u_udlf_checker (
	.clk, .arst_n, .in_valid, .in_ready, .in_byte,
	.out_valid, .out_ready, .out_byte, .run_last
);
